FILE: src/rsps_pkg.sv
package rsps_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int NAME_BYTES_DEF = 19;
  localparam int NAME_BYTES_MAX = 19;
  localparam int NAME_W_MAX     = NAME_BYTES_MAX * 8;

  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_DOWN,
    CM_UP
  } cell_mode_t;

endpackage

FILE: src/rsps_cell.sv
module rsps_cell #(
  parameter int W = 172
) (
  input  logic                    clk,
  input  rsps_pkg::cell_mode_t    mode,
  input  logic [W-1:0]            prev_d,
  input  logic [W-1:0]            next_d,
  output logic [W-1:0]            d
);

  logic [W-1:0] d_r;
  logic [W-1:0] d_nxt;

  always_comb begin
    case (mode)
      rsps_pkg::CM_HOLD: d_nxt = d_r;
      rsps_pkg::CM_DOWN: d_nxt = prev_d;
      rsps_pkg::CM_UP:   d_nxt = next_d;
      default:           d_nxt = d_r;
    endcase
  end

  // payload only: no reset
  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d = d_r;

endmodule

FILE: src/record_stack_with_prefix_search.sv
// Bounded LIFO of records (vision, height, name) with search by name prefix.
// A transaction is accepted on a rising edge with start high and busy low; every
// result sits on the out_ ports for exactly one cycle with out_strobe high and
// cannot be held off, so the receiver must take each one as it comes. Push, pop
// and peek put their result out in the cycle after acceptance and busy stays
// low, so such transactions may follow each other back to back. A search keeps
// busy high while the records circulate once round the chain of DEPTH cells,
// one cell step a cycle; the record leaving the last cell is compared each step
// (bottom of the stack first); a matching record is presented the next cycle,
// and the final count result follows after the last step. The user must write
// the capacity register (cfg_we/cfg_wdata) only while idle; it is not enforced.
module record_stack_with_prefix_search #(
  parameter int DEPTH      = rsps_pkg::DEPTH_DEF,
  parameter int NAME_BYTES = rsps_pkg::NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_vision,
  input  logic [9:0]  in_height,
  input  logic [63:0] in_name_a,
  input  logic [63:0] in_name_b,
  input  logic [23:0] in_name_c,
  input  logic [4:0]  in_query_len,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [9:0]  out_vision,
  output logic [9:0]  out_height,
  output logic [63:0] out_name_a,
  output logic [63:0] out_name_b,
  output logic [23:0] out_name_c,
  output logic [4:0]  out_match_count,
  output logic [4:0]  out_entries_held,
  output logic        out_last
);

  localparam int NW    = NAME_BYTES * 8;
  localparam int REC_W = 20 + NW;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int JW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         fill_r;
  logic [CW-1:0]         count_r;
  logic [JW-1:0]         step_r;
  logic [4:0]            cap_r;
  logic [NW-1:0]         qname_r;
  logic [4:0]            qlen_r;

  logic                  out_strobe_r;
  logic [2:0]            out_status_r;
  logic [REC_W-1:0]      out_rec_r;
  logic [4:0]            out_count_r;
  logic [4:0]            out_held_r;
  logic                  out_last_r;

  rsps_pkg::cell_mode_t  mode;
  logic [REC_W-1:0]      cell_d [DEPTH];
  logic [REC_W-1:0]      head_in;
  logic [REC_W-1:0]      push_rec;
  logic [rsps_pkg::NAME_W_MAX-1:0] in_name_all;
  logic [rsps_pkg::NAME_W_MAX-1:0] out_name_all;
  logic [REC_W-1:0]      tap;
  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic                  tap_held;
  logic                  tap_match;
  logic                  hit;
  logic [4:0]            qlen_clamped;
  logic [EW-1:0]         fill_ext;
  logic [EW-1:0]         cap_ext;
  logic [EW-1:0]         count_ext;
  logic [CW:0]           step_plus_fill;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign in_name_all = {in_name_c, in_name_b, in_name_a};
  // bytes beyond NAME_BYTES are simply not kept
  assign push_rec    = {in_vision, in_height, in_name_all[NW-1:0]};
  assign tap         = cell_d[DEPTH-1];

  assign fill_ext  = EW'(fill_r);
  assign cap_ext   = EW'(cap_r);
  assign count_ext = EW'(count_r);

  // Capacity above DEPTH behaves as DEPTH; below the fill level, push fails
  assign is_full  = (fill_ext >= cap_ext) || (fill_r == CW'(DEPTH));
  assign is_empty = (fill_r == '0);

  assign qlen_clamped = (in_query_len > 5'(NAME_BYTES)) ? 5'(NAME_BYTES) : in_query_len;

  // Step j shows the record that started at index DEPTH-1-j; it is held when
  // that index lies below the fill level
  assign step_plus_fill = (CW + 1)'(step_r) + (CW + 1)'(fill_r);
  assign tap_held       = (step_plus_fill >= (CW + 1)'(DEPTH));

  always_comb begin
    tap_match = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if ((5'(b) < qlen_r) && (tap[b*8 +: 8] != qname_r[b*8 +: 8])) begin
        tap_match = 1'b0;
      end
    end
  end

  assign hit = tap_held && tap_match;

  // Chain control: push shifts towards the bottom, pop towards the top,
  // search rotates the whole ring once
  always_comb begin
    mode    = rsps_pkg::CM_HOLD;
    head_in = push_rec;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            rsps_pkg::OP_PUSH: if (!is_full) mode = rsps_pkg::CM_DOWN;
            rsps_pkg::OP_POP:  if (!is_empty) mode = rsps_pkg::CM_UP;
            default:           mode = rsps_pkg::CM_HOLD;
          endcase
        end
      end
      S_SEARCH: begin
        mode    = rsps_pkg::CM_DOWN;
        head_in = tap;
      end
      default: mode = rsps_pkg::CM_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [REC_W-1:0] prev_d;
    logic [REC_W-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_d = head_in;
    end else begin : g_body
      assign prev_d = cell_d[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_d = cell_d[i];
    end else begin : g_mid
      assign next_d = cell_d[i+1];
    end
    rsps_cell #(.W(REC_W)) u_cell (
      .clk    (clk),
      .mode   (mode),
      .prev_d (prev_d),
      .next_d (next_d),
      .d      (cell_d[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      count_r      <= '0;
      step_r       <= '0;
      cap_r        <= rsps_pkg::CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_opcode)
              rsps_pkg::OP_PUSH: begin
                out_strobe_r <= 1'b1;
                out_rec_r    <= '0;
                out_count_r  <= '0;
                out_last_r   <= 1'b1;
                if (is_full) begin
                  out_status_r <= rsps_pkg::ST_FULL;
                  out_held_r   <= fill_ext[4:0];
                end else begin
                  out_status_r <= rsps_pkg::ST_OK;
                  out_held_r   <= 5'(fill_ext + EW'(1));
                  fill_r       <= fill_r + CW'(1);
                end
              end
              rsps_pkg::OP_POP, rsps_pkg::OP_PEEK: begin
                out_strobe_r <= 1'b1;
                out_count_r  <= '0;
                out_last_r   <= 1'b1;
                if (is_empty) begin
                  out_status_r <= rsps_pkg::ST_EMPTY;
                  out_rec_r    <= '0;
                  out_held_r   <= fill_ext[4:0];
                end else begin
                  out_status_r <= rsps_pkg::ST_OK;
                  out_rec_r    <= cell_d[0];
                  if (in_opcode == rsps_pkg::OP_POP) begin
                    out_held_r <= 5'(fill_ext - EW'(1));
                    fill_r     <= fill_r - CW'(1);
                  end else begin
                    out_held_r <= fill_ext[4:0];
                  end
                end
              end
              default: begin
                qname_r <= in_name_all[NW-1:0];
                qlen_r  <= qlen_clamped;
                step_r  <= '0;
                count_r <= '0;
                state_r <= S_SEARCH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            out_strobe_r <= 1'b1;
            out_status_r <= rsps_pkg::ST_MATCH;
            out_rec_r    <= tap;
            out_count_r  <= '0;
            out_held_r   <= fill_ext[4:0];
            out_last_r   <= 1'b0;
            count_r      <= count_r + CW'(1);
          end
          step_r <= step_r + JW'(1);
          if (step_r == JW'(DEPTH - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_strobe_r <= 1'b1;
          out_status_r <= rsps_pkg::ST_DONE;
          out_rec_r    <= '0;
          out_count_r  <= count_ext[4:0];
          out_held_r   <= fill_ext[4:0];
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Unpack the result record; name bytes beyond NAME_BYTES read as zero
  always_comb begin
    out_name_all         = '0;
    out_name_all[NW-1:0] = out_rec_r[NW-1:0];
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_vision       = out_rec_r[REC_W-1 -: 10];
  assign out_height       = out_rec_r[REC_W-11 -: 10];
  assign out_name_a       = out_name_all[63:0];
  assign out_name_b       = out_name_all[127:64];
  assign out_name_c       = out_name_all[151:128];
  assign out_match_count  = out_count_r;
  assign out_entries_held = out_held_r;
  assign out_last         = out_last_r;

  // Fill level never passes the number of cells
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill level beyond depth");

  // A search never changes the fill level
  a_search_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |=> $stable(fill_r))
    else $error("fill level moved during search");

  // Matches counted never exceed records held
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> (count_r <= fill_r))
    else $error("match count above fill level");

  // A matching record is never the final result of its transaction
  a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == rsps_pkg::ST_MATCH)) |-> !out_last)
    else $error("match result marked last");

endmodule

FILE: tb/tb_record_stack_with_prefix_search.sv
module tb_record_stack_with_prefix_search;

  localparam int DEPTH       = rsps_pkg::DEPTH_DEF;
  localparam int NAME_BYTES  = rsps_pkg::NAME_BYTES_DEF;
  localparam int NAME_W      = rsps_pkg::NAME_W_MAX;
  // Margin that outlasts the span for which a search keeps the block busy.
  localparam int SETTLE      = DEPTH + 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_OPS  = 420;
  localparam int CALM_TAIL   = 50;

  // Kinds of entry in the stimulus backlog
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_CFG   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  typedef struct packed {
    logic [9:0]        vision;
    logic [9:0]        height;
    logic [NAME_W-1:0] name;
  } rec_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        op;
    logic [9:0]        vision;
    logic [9:0]        height;
    logic [NAME_W-1:0] name;
    logic [4:0]        qlen;
    logic [4:0]        cap;
  } step_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  vision;
    logic [9:0]  height;
    logic [63:0] name_a;
    logic [63:0] name_b;
    logic [23:0] name_c;
    logic [4:0]  count;
    logic [4:0]  held;
    logic        last;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [9:0]  in_vision;
  logic [9:0]  in_height;
  logic [63:0] in_name_a;
  logic [63:0] in_name_b;
  logic [23:0] in_name_c;
  logic [4:0]  in_query_len;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [9:0]  out_vision;
  logic [9:0]  out_height;
  logic [63:0] out_name_a;
  logic [63:0] out_name_b;
  logic [23:0] out_name_c;
  logic [4:0]  out_match_count;
  logic [4:0]  out_entries_held;
  logic        out_last;

  // Stimulus backlog, the results still awaited, and the shadow copy of the stack
  step_t       op_backlog[$];
  reply_t      stack_replies[$];
  rec_t        shadow_recs[DEPTH];
  int unsigned shadow_fill;
  logic [4:0]  shadow_cap;

  step_t       cur_cmd;
  logic [NAME_W-1:0] name_pool[3];

  int gap_left;
  bit gaps_on;
  int quiet_run;
  int stall_cycles;
  int n_faults;
  int n_sent;
  int n_results;
  int n_cfg;
  int n_match;
  int n_full;
  int n_empty;

  record_stack_with_prefix_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_vision        (in_vision),
    .in_height        (in_height),
    .in_name_a        (in_name_a),
    .in_name_b        (in_name_b),
    .in_name_c        (in_name_c),
    .in_query_len     (in_query_len),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_vision       (out_vision),
    .out_height       (out_height),
    .out_name_a       (out_name_a),
    .out_name_b       (out_name_b),
    .out_name_c       (out_name_c),
    .out_match_count  (out_match_count),
    .out_entries_held (out_entries_held),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stack predictor
  // ---------------------------------------------------------------------------

  function automatic reply_t reply_from_rec(input logic [2:0] st, input rec_t rc);
    reply_t r;
    r        = '0;
    r.status = st;
    r.vision = rc.vision;
    r.height = rc.height;
    r.name_a = rc.name[63:0];
    r.name_b = rc.name[127:64];
    r.name_c = rc.name[151:128];
    return r;
  endfunction

  // Apply one accepted transaction to the shadow stack and queue every result
  // that it must produce, in order.
  function automatic void apply_stack_op(input step_t s);
    reply_t      r;
    rec_t        rc;
    int unsigned room;
    int unsigned qn;
    int unsigned hits;
    bit          hit;
    r = '0;
    case (s.op)
      rsps_pkg::OP_PUSH: begin
        room = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
        if (shadow_fill >= room) begin
          r.status = rsps_pkg::ST_FULL;
          n_full++;
        end else begin
          rc.vision = s.vision;
          rc.height = s.height;
          rc.name   = s.name;
          // name bytes past NAME_BYTES are never kept
          for (int j = NAME_BYTES; j < rsps_pkg::NAME_BYTES_MAX; j++) rc.name[j*8 +: 8] = '0;
          shadow_recs[shadow_fill] = rc;
          shadow_fill++;
          r.status = rsps_pkg::ST_OK;
        end
      end
      rsps_pkg::OP_POP, rsps_pkg::OP_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = rsps_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r = reply_from_rec(rsps_pkg::ST_OK, shadow_recs[shadow_fill - 1]);
          if (s.op == rsps_pkg::OP_POP) shadow_fill--;
        end
      end
      rsps_pkg::OP_SEARCH: begin
        // over-long queries compare the whole name
        qn   = (s.qlen > NAME_BYTES) ? NAME_BYTES : s.qlen;
        hits = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          hit = 1'b1;
          for (int j = 0; j < qn; j++)
            if (shadow_recs[i].name[j*8 +: 8] != s.name[j*8 +: 8]) hit = 1'b0;
          if (hit) begin
            r      = reply_from_rec(rsps_pkg::ST_MATCH, shadow_recs[i]);
            r.held = 5'(shadow_fill);
            r.last = 1'b0;
            stack_replies.push_back(r);
            hits++;
          end
        end
        n_match += hits;
        r        = '0;
        r.status = rsps_pkg::ST_DONE;
        r.count  = 5'(hits);
      end
      default: ;
    endcase
    r.held = 5'(shadow_fill);
    r.last = 1'b1;
    stack_replies.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [NAME_W-1:0] rand_name();
    logic [159:0] w;
    for (int k = 0; k < 5; k++) w[k*32 +: 32] = $urandom;
    return w[NAME_W-1:0];
  endfunction

  // Mostly names that share a leading run of bytes with a pool entry, so that
  // prefix searches hit at many depths; now and then a fully random name.
  function automatic logic [NAME_W-1:0] pick_name();
    logic [NAME_W-1:0] nm;
    int keep;
    if ($urandom_range(0, 7) == 0) return rand_name();
    nm   = name_pool[$urandom_range(0, 2)];
    keep = $urandom_range(0, NAME_BYTES);
    for (int j = keep; j < rsps_pkg::NAME_BYTES_MAX; j++)
      nm[j*8 +: 8] = 8'($urandom_range(0, 255));
    return nm;
  endfunction

  task automatic add_cmd(input logic [1:0] op, input logic [9:0] vis, input logic [9:0] hgt,
                         input logic [NAME_W-1:0] nm, input logic [4:0] ql);
    step_t s;
    s        = '0;
    s.kind   = KIND_CMD;
    s.op     = op;
    s.vision = vis;
    s.height = hgt;
    s.name   = nm;
    s.qlen   = ql;
    op_backlog.push_back(s);
  endtask

  task automatic add_ctrl(input logic [1:0] kind, input logic [4:0] cap);
    step_t s;
    s      = '0;
    s.kind = kind;
    s.cap  = cap;
    op_backlog.push_back(s);
  endtask

  function automatic logic [4:0] rand_qlen();
    return 5'(($urandom_range(0, 5) == 0) ? $urandom_range(20, 31)
                                          : $urandom_range(0, NAME_BYTES));
  endfunction

  function automatic logic [9:0] rand_val10();
    return 10'($urandom_range(0, 1023));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed the backlog into the block, one transaction per handshake
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : feed
    logic  nxt_start;
    logic  nxt_we;
    step_t nx;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        apply_stack_op(cur_cmd);
        n_sent++;
        nxt_start = 1'b0;
        // open an idle burst now and then, never in the calm tail of the run
        if (gaps_on && op_backlog.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 10);
        if ($urandom_range(0, 24) == 0) gaps_on = !gaps_on;
      end
      // count cycles with nothing in flight, for register writes
      if (stack_replies.size() == 0 && !busy && !start) quiet_run++;
      else quiet_run = 0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_backlog.size() > 0) begin
          nx = op_backlog[0];
          case (nx.kind)
            KIND_CMD: begin
              void'(op_backlog.pop_front());
              cur_cmd      = nx;
              in_opcode    <= nx.op;
              in_vision    <= nx.vision;
              in_height    <= nx.height;
              in_name_a    <= nx.name[63:0];
              in_name_b    <= nx.name[127:64];
              in_name_c    <= nx.name[151:128];
              in_query_len <= nx.qlen;
              nxt_start    = 1'b1;
            end
            KIND_CFG: begin
              // write capacity only once the block has been idle long enough
              if (quiet_run >= SETTLE) begin
                void'(op_backlog.pop_front());
                nxt_we     = 1'b1;
                cfg_wdata  <= nx.cap;
                shadow_cap = nx.cap;
                quiet_run  = 0;
                n_cfg++;
              end
            end
            KIND_DRAIN: begin
              // hold off until every awaited result has come
              if (stack_replies.size() == 0) void'(op_backlog.pop_front());
            end
            default: void'(op_backlog.pop_front());
          endcase
        end
      end
    end
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest awaited one
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string fld, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fld, want, got);
      n_faults++;
    end
  endfunction

  always @(posedge clk) begin : results_check
    reply_t want;
    if (rst_n && out_strobe) begin
      n_results++;
      if (stack_replies.size() == 0) begin
        $error("result with nothing awaited: status %0d", out_status);
        n_faults++;
      end else begin
        want = stack_replies.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("vision", 64'(want.vision), 64'(out_vision));
        check_field("height", 64'(want.height), 64'(out_height));
        check_field("name_a", want.name_a, out_name_a);
        check_field("name_b", want.name_b, out_name_b);
        check_field("name_c", 64'(want.name_c), 64'(out_name_c));
        check_field("match_count", 64'(want.count), 64'(out_match_count));
        check_field("entries_held", 64'(want.held), 64'(out_entries_held));
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
    // watchdog: any transaction or register write resets the count
    if (out_strobe === 1'b1 || (start && busy === 1'b0) || cfg_we) stall_cycles = 0;
    else stall_cycles++;
  end

  // ---------------------------------------------------------------------------
  // Scenario: initialise, fill the backlog, release reset, wait for the end
  // ---------------------------------------------------------------------------

  initial begin : scenario
    logic [NAME_W-1:0] nm;
    logic [NAME_W-1:0] ones;
    logic [4:0]        cap_plan[8];
    int                n_rand;
    int                next_cfg;
    int                phase;
    int                burst;

    rst_n        = 1'b0;
    start        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_opcode    = rsps_pkg::OP_PUSH;
    in_vision    = '0;
    in_height    = '0;
    in_name_a    = '0;
    in_name_b    = '0;
    in_name_c    = '0;
    in_query_len = '0;
    cur_cmd      = '0;
    shadow_fill  = 0;
    shadow_cap   = rsps_pkg::CAP_RESET;
    gap_left     = 0;
    gaps_on      = 1'b1;
    quiet_run    = 0;
    stall_cycles = 0;
    n_faults     = 0;
    n_sent       = 0;
    n_results    = 0;
    n_cfg        = 0;
    n_match      = 0;
    n_full       = 0;
    n_empty      = 0;
    ones         = '1;

    // pool entry 1 shares its first six bytes with entry 0
    name_pool[0] = rand_name();
    nm           = rand_name();
    name_pool[1] = {nm[NAME_W-1:48], name_pool[0][47:0]};
    name_pool[2] = rand_name();

    // Directed part: empty stack, field extremes, every operation
    add_cmd(rsps_pkg::OP_POP, 10'd0, 10'd0, '0, 5'd0);
    add_cmd(rsps_pkg::OP_PEEK, 10'd0, 10'd0, '0, 5'd0);
    add_cmd(rsps_pkg::OP_SEARCH, 10'd0, 10'd0, '0, 5'd0);          // finished with count 0
    add_cmd(rsps_pkg::OP_PUSH, 10'd0, 10'd0, '0, 5'd0);
    add_cmd(rsps_pkg::OP_PUSH, 10'd1023, 10'd1023, ones, 5'd31);
    add_cmd(rsps_pkg::OP_PUSH, 10'd512, 10'd341, name_pool[0], 5'd0);
    add_cmd(rsps_pkg::OP_PEEK, 10'd0, 10'd0, '0, 5'd0);
    add_cmd(rsps_pkg::OP_SEARCH, 10'd0, 10'd0, name_pool[2], 5'd0);  // empty query: all match
    add_cmd(rsps_pkg::OP_SEARCH, 10'd0, 10'd0, ones, 5'd31);         // long query
    add_cmd(rsps_pkg::OP_POP, 10'd0, 10'd0, '0, 5'd0);
    add_ctrl(KIND_CFG, 5'd0);                              // capacity below fill level
    add_cmd(rsps_pkg::OP_PUSH, 10'd7, 10'd9, name_pool[1], 5'd0);
    add_cmd(rsps_pkg::OP_PEEK, 10'd0, 10'd0, '0, 5'd0);
    add_ctrl(KIND_DRAIN, 5'd0);
    add_ctrl(KIND_CFG, 5'd31);                             // capacity above DEPTH
    for (int k = 0; k < DEPTH - 2; k++)
      add_cmd(rsps_pkg::OP_PUSH, rand_val10(), rand_val10(), pick_name(), 5'd0);
    add_cmd(rsps_pkg::OP_PUSH, 10'd1, 10'd1, name_pool[0], 5'd0);     // full at DEPTH
    add_cmd(rsps_pkg::OP_SEARCH, 10'd0, 10'd0, '0, 5'd0);            // every record matches
    add_ctrl(KIND_CFG, 5'd16);

    // Random part: phases of capacity, mostly push runs followed by searches
    cap_plan = '{5'd5, 5'd0, 5'd16, 5'd31, 5'd1, 5'd12, 5'd17, 5'd8};
    n_rand   = 0;
    next_cfg = 0;
    phase    = 0;
    while (n_rand < RANDOM_OPS) begin
      if (n_rand >= next_cfg) begin
        if (phase == 3) add_ctrl(KIND_DRAIN, 5'd0);
        add_ctrl(KIND_CFG, cap_plan[phase % 8]);
        phase++;
        next_cfg += $urandom_range(50, 65);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++)
            add_cmd(rsps_pkg::OP_PUSH, rand_val10(), rand_val10(), pick_name(),
                    5'($urandom_range(0, 31)));
          n_rand += burst;
          burst = $urandom_range(1, 3);
          for (int k = 0; k < burst; k++)
            add_cmd(rsps_pkg::OP_SEARCH, rand_val10(), rand_val10(), pick_name(),
                    rand_qlen());
          n_rand += burst;
        end
        5, 6, 7: begin
          burst = $urandom_range(1, 10);
          for (int k = 0; k < burst; k++)
            add_cmd(($urandom_range(0, 3) == 0) ? rsps_pkg::OP_PEEK : rsps_pkg::OP_POP,
                    rand_val10(), rand_val10(), rand_name(), 5'($urandom_range(0, 31)));
          n_rand += burst;
        end
        default: begin
          // noise: any operation, any field values
          add_cmd(2'($urandom_range(0, 3)), rand_val10(), rand_val10(),
                  rand_name(), 5'($urandom_range(0, 31)));
          n_rand++;
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the rising edge so the driver and monitor have settled
    @(negedge clk);
    while (!(op_backlog.size() == 0 && !start && stack_replies.size() == 0)
           && stall_cycles < STALL_LIMIT)
      @(negedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results still awaited",
               STALL_LIMIT, stack_replies.size());
      $display("RESULT: ERROR");
    end else begin
      repeat (SETTLE) @(posedge clk);
      $display("Sent %0d transactions over %0d capacity writes; %0d results checked.",
               n_sent, n_cfg, n_results);
      $display("Seen %0d prefix matches, %0d refused pushes, %0d pops or peeks on empty.",
               n_match, n_full, n_empty);
      if (n_faults == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
